// ===== src/glrw_pkg.sv =====
// shared constants, types and helpers for the grid line reachability walk
// no dependencies; imported by every module of the block
`default_nettype none

package glrw_pkg;

    // map geometry
    localparam int unsigned MAP_WIDTH  = 256;
    localparam int unsigned MAP_HEIGHT = 256;
    localparam int unsigned MAP_DEPTH  = MAP_WIDTH * MAP_HEIGHT;
    localparam int unsigned ADDR_W     = $clog2(MAP_DEPTH);

    // coordinate and error widths
    localparam int unsigned COORD_W = 8;
    localparam int unsigned ERR_W   = COORD_W + 3;

    // input word modes
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP_ERR,
        ST_PREP_INC,
        ST_WALK,
        ST_RESULT
    } state_t;

    // sequencer to stepper controls
    typedef struct packed {
        logic load;
        logic prep_err;
        logic prep_inc;
        logic issue;
        logic walk;
    } step_ctl_t;

    // stepper status back to the sequencer
    typedef struct packed {
        logic zero_len;
        logic issue_done;
        logic chk_vld;
        logic chk_fail;
        logic chk_last;
    } step_sts_t;

    // tile address, row major
    function automatic logic [ADDR_W-1:0] tile_addr(
        input logic [COORD_W-1:0] u,
        input logic [COORD_W-1:0] v
    );
        logic [31:0] lin;
        lin = 32'(v) * 32'(MAP_WIDTH) + 32'(u);
        return lin[ADDR_W-1:0];
    endfunction

    // tile lies inside the map
    function automatic logic in_map(
        input logic [COORD_W-1:0] u,
        input logic [COORD_W-1:0] v
    );
        return (32'(u) < 32'(MAP_WIDTH)) && (32'(v) < 32'(MAP_HEIGHT));
    endfunction

endpackage

`default_nettype wire

// ===== src/glrw_map.sv =====
// one-bit reachability map memory with a set-to-ones pass after reset
// depends on glrw_pkg for the map depth and address width
`default_nettype none

module glrw_map
    import glrw_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic              wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic                   rd_data,
    output logic                   busy
);

    logic              mem [MAP_DEPTH];
    logic              busy_reg, busy_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic              rd_data_reg;

    // clearing pass control
    always_comb begin
        busy_next     = busy_reg;
        clr_addr_next = clr_addr_reg;
        if (busy_reg) begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == ADDR_W'(MAP_DEPTH - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            busy_reg     <= busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // single write port, shared by the clearing pass and tile writes
    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            mem[clr_addr_reg] <= 1'b1;
        end else if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

endmodule

`default_nettype wire

// ===== src/glrw_step.sv =====
// bresenham stepper: span setup, shared error adder, pixel issue and check
// depends on glrw_pkg for widths, control types and address helpers
`default_nettype none

module glrw_step
    import glrw_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire step_ctl_t          ctl,
    input  wire logic [COORD_W-1:0] from_u,
    input  wire logic [COORD_W-1:0] from_v,
    input  wire logic [COORD_W-1:0] to_u,
    input  wire logic [COORD_W-1:0] to_v,
    input  wire logic               rd_data,
    output logic                    rd_en,
    output logic [ADDR_W-1:0]       rd_addr,
    output step_sts_t               sts,
    output logic [COORD_W-1:0]      stop_u,
    output logic [COORD_W-1:0]      stop_v
);

    logic [COORD_W-1:0] major_reg, major_next;
    logic [COORD_W-1:0] minor_reg, minor_next;
    logic               swap_reg, swap_next;
    logic               neg_u_reg, neg_u_next;
    logic               neg_v_reg, neg_v_next;
    logic [ERR_W-1:0]   err_reg, err_next;
    logic [ERR_W-1:0]   inc_b_reg, inc_b_next;
    logic [COORD_W-1:0] cur_u_reg, cur_u_next;
    logic [COORD_W-1:0] cur_v_reg, cur_v_next;
    logic [COORD_W-1:0] cnt_reg, cnt_next;
    logic               chk_vld_reg, chk_vld_next;
    logic               chk_in_reg, chk_in_next;
    logic               chk_last_reg, chk_last_next;
    logic [COORD_W-1:0] chk_u_reg, chk_u_next;
    logic [COORD_W-1:0] chk_v_reg, chk_v_next;
    logic [COORD_W-1:0] prev_u_reg, prev_u_next;
    logic [COORD_W-1:0] prev_v_reg, prev_v_next;

    logic [COORD_W-1:0] adu, adv;
    logic               du_neg, dv_neg;
    logic [ERR_W-1:0]   two_minor, two_major;
    logic [ERR_W-1:0]   opa, opb, sum;
    logic               sub;
    logic               err_pos;
    logic               cur_in;
    logic               chk_fail;

    // span magnitudes and directions from the query word
    always_comb begin
        du_neg = to_u < from_u;
        dv_neg = to_v < from_v;
        adu    = du_neg ? (from_u - to_u) : (to_u - from_u);
        adv    = dv_neg ? (from_v - to_v) : (to_v - from_v);
    end

    assign two_minor = ERR_W'({minor_reg, 1'b0});
    assign two_major = ERR_W'({major_reg, 1'b0});
    assign err_pos   = !err_reg[ERR_W-1] && (err_reg != '0);

    // shared adder/subtractor for the error term
    always_comb begin
        opa = err_reg;
        opb = err_pos ? inc_b_reg : two_minor;
        sub = 1'b0;
        if (ctl.prep_err) begin
            opa = two_minor;
            opb = ERR_W'(major_reg);
            sub = 1'b1;
        end else if (ctl.prep_inc) begin
            opa = two_minor;
            opb = two_major;
            sub = 1'b1;
        end
        sum = opa + (opb ^ {ERR_W{sub}}) + ERR_W'(sub);
    end

    assign cur_in   = in_map(cur_u_reg, cur_v_reg);
    assign chk_fail = !(rd_data && chk_in_reg);

    // next state of the stepper
    always_comb begin
        major_next    = major_reg;
        minor_next    = minor_reg;
        swap_next     = swap_reg;
        neg_u_next    = neg_u_reg;
        neg_v_next    = neg_v_reg;
        err_next      = err_reg;
        inc_b_next    = inc_b_reg;
        cur_u_next    = cur_u_reg;
        cur_v_next    = cur_v_reg;
        cnt_next      = cnt_reg;
        chk_vld_next  = ctl.issue;
        chk_in_next   = chk_in_reg;
        chk_last_next = chk_last_reg;
        chk_u_next    = chk_u_reg;
        chk_v_next    = chk_v_reg;
        prev_u_next   = prev_u_reg;
        prev_v_next   = prev_v_reg;

        if (ctl.load) begin
            swap_next    = adv > adu;
            major_next   = (adv > adu) ? adv : adu;
            minor_next   = (adv > adu) ? adu : adv;
            neg_u_next   = du_neg;
            neg_v_next   = dv_neg;
            cur_u_next   = from_u;
            cur_v_next   = from_v;
            prev_u_next  = from_u;
            prev_v_next  = from_v;
            cnt_next     = '0;
            chk_vld_next = 1'b0;
        end

        if (ctl.prep_err) begin
            err_next = sum;
        end
        if (ctl.prep_inc) begin
            inc_b_next = sum;
        end

        // issue one pixel and advance along the line
        if (ctl.issue) begin
            chk_in_next   = cur_in;
            chk_last_next = (cnt_reg + 1'b1) == major_reg;
            chk_u_next    = cur_u_reg;
            chk_v_next    = cur_v_reg;
            cnt_next      = cnt_reg + 1'b1;
            err_next      = sum;
            if (swap_reg || err_pos) begin
                cur_v_next = neg_v_reg ? (cur_v_reg - 1'b1) : (cur_v_reg + 1'b1);
            end
            if (!swap_reg || err_pos) begin
                cur_u_next = neg_u_reg ? (cur_u_reg - 1'b1) : (cur_u_reg + 1'b1);
            end
        end

        // a passed pixel becomes the previous one unless the walk ends here
        if (ctl.walk && chk_vld_reg && !chk_fail && !chk_last_reg) begin
            prev_u_next = chk_u_reg;
            prev_v_next = chk_v_reg;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chk_vld_reg <= 1'b0;
        end else begin
            chk_vld_reg <= chk_vld_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        major_reg    <= major_next;
        minor_reg    <= minor_next;
        swap_reg     <= swap_next;
        neg_u_reg    <= neg_u_next;
        neg_v_reg    <= neg_v_next;
        err_reg      <= err_next;
        inc_b_reg    <= inc_b_next;
        cur_u_reg    <= cur_u_next;
        cur_v_reg    <= cur_v_next;
        cnt_reg      <= cnt_next;
        chk_in_reg   <= chk_in_next;
        chk_last_reg <= chk_last_next;
        chk_u_reg    <= chk_u_next;
        chk_v_reg    <= chk_v_next;
        prev_u_reg   <= prev_u_next;
        prev_v_reg   <= prev_v_next;
    end

    // map read and status
    assign rd_en   = ctl.issue && cur_in;
    assign rd_addr = tile_addr(cur_u_reg, cur_v_reg);

    always_comb begin
        sts.zero_len   = major_reg == '0;
        sts.issue_done = cnt_reg == major_reg;
        sts.chk_vld    = chk_vld_reg;
        sts.chk_fail   = chk_fail;
        sts.chk_last   = chk_last_reg;
    end

    assign stop_u = prev_u_reg;
    assign stop_v = prev_v_reg;

endmodule

`default_nettype wire

// ===== src/grid_line_reachability_walk.sv =====
// Grid line reachability walk, top level: sequencer, output register, map and stepper.
// Depends on glrw_pkg, glrw_map and glrw_step.
//
// Input channel (s_valid/s_ready): a word with s_mode = 0 writes s_tile_open to
// tile (s_from_u, s_from_v) and gives no result; writes outside the map are dropped.
// A word with s_mode = 1 walks a Bresenham line from the start to the end tile
// and gives one result word on the m_ channel: m_clear and the stop tile.
// From acceptance to m_valid a query runs the setup states ST_PREP_ERR and ST_PREP_INC
// through the shared error adder, then one map read per pixel (the single read port of
// the map sets this), unless the span is zero; the last read returns to the check
// register and the result is loaded into the output register. A blocked pixel ends
// the walk early. The block takes no new word while a query runs.
// After reset the map is set to all ones by a pass over all MAP_DEPTH tiles
// (65536 at 256 x 256); s_ready stays low during that pass.
// The result sits in an output register; if the receiver stalls, a finished
// query waits until m_ready before the block goes idle again, while a result
// already held does not stop writes or the start of the next query.
`default_nettype none

module grid_line_reachability_walk
    import glrw_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_mode,
    input  wire logic [COORD_W-1:0] s_from_u,
    input  wire logic [COORD_W-1:0] s_from_v,
    input  wire logic [COORD_W-1:0] s_to_u,
    input  wire logic [COORD_W-1:0] s_to_v,
    input  wire logic               s_tile_open,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_clear,
    output logic [COORD_W-1:0]      m_stop_u,
    output logic [COORD_W-1:0]      m_stop_v
);

    state_t             state_reg, state_next;
    logic               m_valid_reg, m_valid_next;
    logic               m_clear_reg, m_clear_next;
    logic [COORD_W-1:0] m_stop_u_reg, m_stop_u_next;
    logic [COORD_W-1:0] m_stop_v_reg, m_stop_v_next;
    logic               clear_reg, clear_next;

    step_ctl_t          ctl;
    step_sts_t          sts;
    logic               map_busy;
    logic               map_rd_en;
    logic [ADDR_W-1:0]  map_rd_addr;
    logic               map_rd_data;
    logic               wr_en;
    logic               accept;
    logic               finish;
    logic               out_load;
    logic [COORD_W-1:0] stop_u, stop_v;

    // tile map
    glrw_map u_map (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_en),
        .wr_addr (tile_addr(s_from_u, s_from_v)),
        .wr_data (s_tile_open),
        .rd_en   (map_rd_en),
        .rd_addr (map_rd_addr),
        .rd_data (map_rd_data),
        .busy    (map_busy)
    );

    // line stepper
    glrw_step u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .from_u  (s_from_u),
        .from_v  (s_from_v),
        .to_u    (s_to_u),
        .to_v    (s_to_v),
        .rd_data (map_rd_data),
        .rd_en   (map_rd_en),
        .rd_addr (map_rd_addr),
        .sts     (sts),
        .stop_u  (stop_u),
        .stop_v  (stop_v)
    );

    assign accept = s_valid && s_ready;
    assign finish = (state_reg == ST_WALK) && sts.chk_vld && (sts.chk_fail || sts.chk_last);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (s_mode == MODE_QUERY)) begin
                    state_next = ST_PREP_ERR;
                end
            end
            ST_PREP_ERR: begin
                state_next = ST_PREP_INC;
            end
            ST_PREP_INC: begin
                state_next = sts.zero_len ? ST_RESULT : ST_WALK;
            end
            ST_WALK: begin
                if (finish) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_ready      = (state_reg == ST_IDLE) && !map_busy;
        wr_en        = accept && (s_mode == MODE_WRITE) && in_map(s_from_u, s_from_v);
        ctl.load     = accept && (s_mode == MODE_QUERY);
        ctl.prep_err = state_reg == ST_PREP_ERR;
        ctl.prep_inc = state_reg == ST_PREP_INC;
        ctl.walk     = state_reg == ST_WALK;
        ctl.issue    = (state_reg == ST_WALK) && !sts.issue_done && !finish;
        out_load     = (state_reg == ST_RESULT) && (!m_valid_reg || m_ready);
    end

    // result flag and output register
    always_comb begin
        clear_next = clear_reg;
        if (ctl.prep_inc && sts.zero_len) begin
            clear_next = 1'b1;
        end else if (finish) begin
            clear_next = !sts.chk_fail;
        end

        m_valid_next  = m_valid_reg && !m_ready;
        m_clear_next  = m_clear_reg;
        m_stop_u_next = m_stop_u_reg;
        m_stop_v_next = m_stop_v_reg;
        if (out_load) begin
            m_valid_next  = 1'b1;
            m_clear_next  = clear_reg;
            m_stop_u_next = stop_u;
            m_stop_v_next = stop_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        clear_reg    <= clear_next;
        m_clear_reg  <= m_clear_next;
        m_stop_u_reg <= m_stop_u_next;
        m_stop_v_reg <= m_stop_v_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_clear  = m_clear_reg;
    assign m_stop_u = m_stop_u_reg;
    assign m_stop_v = m_stop_v_reg;

`ifndef ASSERT_OFF
    // no word is taken while the map is being set after reset
    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        map_busy |-> !s_ready)
        else $error("input taken during map clearing pass");

    // a query word always starts the setup sequence
    a_query_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_mode == MODE_QUERY)) |=> (state_reg == ST_PREP_ERR))
        else $error("query accepted without setup");

    // read data checked during the walk belongs to a pixel issued the cycle before
    a_check_follows_issue: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_WALK) && sts.chk_vld) |-> $past(ctl.issue))
        else $error("pixel checked without a matching read");

    // never more pixels than the major span
    a_issue_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.issue |-> !sts.issue_done)
        else $error("pixel issued past the end of the line");
`endif

endmodule

`default_nettype wire
